[hw/rtl/sdvmg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdvmg_pkg
// Types, register map and gain table of the stereo dB volume control.
// ----------------------------------------------------------------------------
package sdvmg_pkg;

  localparam int unsigned SampleW   = 32;
  localparam int unsigned VolW      = 16;
  localparam int unsigned GainW     = 32;
  localparam int unsigned GainSteps = 97;
  localparam int unsigned IdxW      = $clog2(GainSteps);
  localparam int unsigned DbOffset  = 96;
  localparam int unsigned GainShift = 31;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;
  localparam int unsigned ProdW     = SampleW + GainW + 1;

  localparam logic [2:0] RegMasterVol  = 3'd0;
  localparam logic [2:0] RegLeftVol    = 3'd1;
  localparam logic [2:0] RegRightVol   = 3'd2;
  localparam logic [2:0] RegMasterMute = 3'd3;
  localparam logic [2:0] RegLeftMute   = 3'd4;
  localparam logic [2:0] RegRightMute  = 3'd5;

  typedef struct packed {
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
  } frame_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
  } frame_out_t;

  localparam logic [GainW-1:0] GainRom [GainSteps] = '{
    32'h000084f3, 32'h0000952c, 32'h0000a760, 32'h0000bbcc, 32'h0000d2b6, 32'h0000ec6c,
    32'h00010945, 32'h000129a4, 32'h00014df5, 32'h000176b5, 32'h0001a46d, 32'h0001d7ba,
    32'h00021149, 32'h000251de, 32'h00029a55, 32'h0002eba3, 32'h000346dc, 32'h0003ad38,
    32'h00042010, 32'h0004a0ec, 32'h00053181, 32'h0005d3bb, 32'h000689bf, 32'h000755fa,
    32'h00083b20, 32'h00093c3b, 32'h000a5cb6, 32'h000ba064, 32'h000d0b91, 32'h000ea30e,
    32'h00106c43, 32'h00126d43, 32'h0014acdb, 32'h001732ae, 32'h001a074f, 32'h001d345b,
    32'h0020c49c, 32'h0024c42c, 32'h002940a2, 32'h002e4939, 32'h0033ef0c, 32'h003a454a,
    32'h00416179, 32'h00495bc1, 32'h00524f3b, 32'h005c5a4f, 32'h00679f1c, 32'h007443e8,
    32'h008273a6, 32'h00925e89, 32'h00a43aa2, 32'h00b8449c, 32'h00cec08a, 32'h00e7facc,
    32'h01044915, 32'h01240b8c, 32'h0147ae14, 32'h016fa9bb, 32'h019c8651, 32'h01cedc3d,
    32'h0207567a, 32'h0246b4e4, 32'h028dcebc, 32'h02dd958a, 32'h0337184e, 32'h039b8719,
    32'h040c3714, 32'h048aa70b, 32'h05188480, 32'h05b7b15b, 32'h066a4a53, 32'h0732ae18,
    32'h08138562, 32'h090fcbf8, 32'h0a2adad2, 32'h0b68737a, 32'h0ccccccd, 32'h0e5ca14c,
    32'h101d3f2e, 32'h12149a60, 32'h144960c5, 32'h16c310e3, 32'h198a1357, 32'h1ca7d768,
    32'h2026f310, 32'h241346f6, 32'h287a26c5, 32'h2d6a866f, 32'h32f52cff, 32'h392ced8e,
    32'h4026e73d, 32'h47faccf0, 32'h50c335d4, 32'h5a9df7ac, 32'h65ac8c2f, 32'h721482c0,
    32'h80000000
  };

  localparam logic [GainW-1:0] GainUnity = GainRom[GainSteps-1];

  function automatic logic [IdxW-1:0] vol_to_idx(input logic signed [VolW-1:0] vol);
    logic signed [7:0] quo;
    logic signed [9:0] sum;
    logic [IdxW-1:0]   idx;
    quo = 8'(vol >>> 8);
    if (vol[VolW-1] && (|vol[7:0])) begin
      quo = quo + 8'sd1;
    end
    sum = 10'(quo) + 10'(DbOffset);
    if (sum < 10'sd0) begin
      idx = '0;
    end else if (sum > 10'(GainSteps - 1)) begin
      idx = IdxW'(GainSteps - 1);
    end else begin
      idx = sum[IdxW-1:0];
    end
    return idx;
  endfunction

  function automatic logic [GainW-1:0] vol_to_gain(input logic signed [VolW-1:0] vol);
    return GainRom[vol_to_idx(vol)];
  endfunction

endpackage

[hw/rtl/stereo_db_volume_mute_gain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_db_volume_mute_gain
// Stereo digital volume control: dB table lookup, channel and master gain,
// mute.
// ----------------------------------------------------------------------------
// A frame is taken at every clock edge with start high; busy stays low,
// so one frame per cycle is sustained. The result passes through four
// stages, the input register, the channel gain multiplier, the master gain
// multiplier and the output register, and leaves on result_o with done_o
// high for one cycle; the receiver cannot stall it. Gains are looked up
// when a volume register is written.
module stereo_db_volume_mute_gain
  import sdvmg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  frame_in_t        frame_i,
  output logic             done_o,
  output frame_out_t       result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic signed [VolW-1:0] master_vol_q, left_vol_q, right_vol_q;
  logic                   master_mute_q, left_mute_q, right_mute_q;
  logic [GainW-1:0]       gain_m_q, gain_l_q, gain_r_q;
  logic                   wr_en;
  logic [2:0]             reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_vol_q  <= '0;
      left_vol_q    <= '0;
      right_vol_q   <= '0;
      master_mute_q <= 1'b0;
      left_mute_q   <= 1'b0;
      right_mute_q  <= 1'b0;
      gain_m_q      <= GainUnity;
      gain_l_q      <= GainUnity;
      gain_r_q      <= GainUnity;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegMasterVol: begin
          master_vol_q <= pwdata[VolW-1:0];
          gain_m_q     <= vol_to_gain(pwdata[VolW-1:0]);
        end
        RegLeftVol: begin
          left_vol_q <= pwdata[VolW-1:0];
          gain_l_q   <= vol_to_gain(pwdata[VolW-1:0]);
        end
        RegRightVol: begin
          right_vol_q <= pwdata[VolW-1:0];
          gain_r_q    <= vol_to_gain(pwdata[VolW-1:0]);
        end
        RegMasterMute: master_mute_q <= pwdata[0];
        RegLeftMute:   left_mute_q   <= pwdata[0];
        RegRightMute:  right_mute_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegMasterVol:  prdata = DataW'(master_vol_q);
      RegLeftVol:    prdata = DataW'(left_vol_q);
      RegRightVol:   prdata = DataW'(right_vol_q);
      RegMasterMute: prdata = DataW'(master_mute_q);
      RegLeftMute:   prdata = DataW'(left_mute_q);
      RegRightMute:  prdata = DataW'(right_mute_q);
      default:       prdata = '0;
    endcase
  end

  // Stage 1: input register
  logic      s1_vld_q;
  frame_in_t s1_q;

  // Stage 2: channel gain product
  logic                    s2_vld_q;
  logic signed [ProdW-1:0] s2_l_q, s2_r_q;

  // Stage 3: master gain product
  logic                    s3_vld_q;
  logic signed [ProdW-1:0] s3_l_q, s3_r_q;

  logic signed [GainW:0]   gl_s, gr_s, gm_s;
  logic signed [SampleW-1:0] m_l, m_r;

  assign gl_s = (master_mute_q || left_mute_q)  ? '0 : $signed({1'b0, gain_l_q});
  assign gr_s = (master_mute_q || right_mute_q) ? '0 : $signed({1'b0, gain_r_q});
  assign gm_s = $signed({1'b0, gain_m_q});
  assign m_l  = s2_l_q[GainShift+SampleW-1:GainShift];
  assign m_r  = s2_r_q[GainShift+SampleW-1:GainShift];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      s1_vld_q <= start;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      done_o   <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      s1_q <= frame_i;
    end
    if (s1_vld_q) begin
      s2_l_q <= ProdW'(s1_q.left_in) * ProdW'(gl_s);
      s2_r_q <= ProdW'(s1_q.right_in) * ProdW'(gr_s);
    end
    if (s2_vld_q) begin
      s3_l_q <= ProdW'(m_l) * ProdW'(gm_s);
      s3_r_q <= ProdW'(m_r) * ProdW'(gm_s);
    end
    if (s3_vld_q) begin
      result_o.left_out  <= s3_l_q[GainShift+SampleW-1:GainShift];
      result_o.right_out <= s3_r_q[GainShift+SampleW-1:GainShift];
    end
  end

endmodule

[verif/stereo_db_volume_mute_gain_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_db_volume_mute_gain_tb
// Self-checking bench for the stereo dB volume control. Frames go in through
// the start/busy handshake and volume and mute settings through the APB port.
// A scoreboard predicts each scaled frame from its own gain table and checks
// each done_o beat against it. A directed part covers sample extremes,
// table-index saturation, truncation toward zero and every mute, followed by
// random frames under several settings and sender idle rates.
// ----------------------------------------------------------------------------
module stereo_db_volume_mute_gain_tb;
  import sdvmg_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int          VolStep    = 256;
  localparam int          ZeroDbIdx  = 96;
  localparam int          ReportMax  = 10;

  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  localparam logic [AddrW-1:0] AdrMasterVol  = {RegMasterVol, 2'b00};
  localparam logic [AddrW-1:0] AdrLeftVol    = {RegLeftVol, 2'b00};
  localparam logic [AddrW-1:0] AdrRightVol   = {RegRightVol, 2'b00};
  localparam logic [AddrW-1:0] AdrMasterMute = {RegMasterMute, 2'b00};
  localparam logic [AddrW-1:0] AdrLeftMute   = {RegLeftMute, 2'b00};
  localparam logic [AddrW-1:0] AdrRightMute  = {RegRightMute, 2'b00};
  localparam logic [AddrW-1:0] AdrSpareLo    = {RegSpareLo, 2'b00};
  localparam logic [AddrW-1:0] AdrSpareHi    = {RegSpareHi, 2'b00};

  localparam logic [SampleW-1:0] MinSample = 32'h8000_0000;
  localparam logic [SampleW-1:0] MaxSample = 32'h7fff_ffff;
  localparam logic [VolW-1:0]    VolFloor  = 16'ha000;
  localparam logic [VolW-1:0]    VolMaxPos = 16'h7fff;
  localparam logic [VolW-1:0]    VolMaxNeg = 16'h8000;

  localparam logic [31:0] DbGain [97] = '{
    32'h000084f3, 32'h0000952c, 32'h0000a760, 32'h0000bbcc, 32'h0000d2b6, 32'h0000ec6c,
    32'h00010945, 32'h000129a4, 32'h00014df5, 32'h000176b5, 32'h0001a46d, 32'h0001d7ba,
    32'h00021149, 32'h000251de, 32'h00029a55, 32'h0002eba3, 32'h000346dc, 32'h0003ad38,
    32'h00042010, 32'h0004a0ec, 32'h00053181, 32'h0005d3bb, 32'h000689bf, 32'h000755fa,
    32'h00083b20, 32'h00093c3b, 32'h000a5cb6, 32'h000ba064, 32'h000d0b91, 32'h000ea30e,
    32'h00106c43, 32'h00126d43, 32'h0014acdb, 32'h001732ae, 32'h001a074f, 32'h001d345b,
    32'h0020c49c, 32'h0024c42c, 32'h002940a2, 32'h002e4939, 32'h0033ef0c, 32'h003a454a,
    32'h00416179, 32'h00495bc1, 32'h00524f3b, 32'h005c5a4f, 32'h00679f1c, 32'h007443e8,
    32'h008273a6, 32'h00925e89, 32'h00a43aa2, 32'h00b8449c, 32'h00cec08a, 32'h00e7facc,
    32'h01044915, 32'h01240b8c, 32'h0147ae14, 32'h016fa9bb, 32'h019c8651, 32'h01cedc3d,
    32'h0207567a, 32'h0246b4e4, 32'h028dcebc, 32'h02dd958a, 32'h0337184e, 32'h039b8719,
    32'h040c3714, 32'h048aa70b, 32'h05188480, 32'h05b7b15b, 32'h066a4a53, 32'h0732ae18,
    32'h08138562, 32'h090fcbf8, 32'h0a2adad2, 32'h0b68737a, 32'h0ccccccd, 32'h0e5ca14c,
    32'h101d3f2e, 32'h12149a60, 32'h144960c5, 32'h16c310e3, 32'h198a1357, 32'h1ca7d768,
    32'h2026f310, 32'h241346f6, 32'h287a26c5, 32'h2d6a866f, 32'h32f52cff, 32'h392ced8e,
    32'h4026e73d, 32'h47faccf0, 32'h50c335d4, 32'h5a9df7ac, 32'h65ac8c2f, 32'h721482c0,
    32'h80000000
  };

  class gain_scoreboard;
    logic signed [VolW-1:0] master_vol;
    logic signed [VolW-1:0] left_vol;
    logic signed [VolW-1:0] right_vol;
    logic                   master_mute;
    logic                   left_mute;
    logic                   right_mute;
    frame_out_t             scaled_q[$];
    int unsigned            mismatches;

    function new();
      master_vol  = '0;
      left_vol    = '0;
      right_vol   = '0;
      master_mute = 1'b0;
      left_mute   = 1'b0;
      right_mute  = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
      case (addr[AddrW-1:2])
        RegMasterVol:  master_vol  = data[VolW-1:0];
        RegLeftVol:    left_vol    = data[VolW-1:0];
        RegRightVol:   right_vol   = data[VolW-1:0];
        RegMasterMute: master_mute = data[0];
        RegLeftMute:   left_mute   = data[0];
        RegRightMute:  right_mute  = data[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] gain_of(logic signed [VolW-1:0] vol);
      int idx;
      idx = int'(vol) / VolStep + ZeroDbIdx;
      if (idx < 0) idx = 0;
      if (idx > ZeroDbIdx) idx = ZeroDbIdx;
      return DbGain[idx];
    endfunction

    function longint apply_gain(longint x, logic [31:0] g);
      longint prod;
      prod = x * longint'({32'd0, g});
      return prod >>> GainShift;
    endfunction

    function int unsigned pending();
      return scaled_q.size();
    endfunction

    function void note_frame(frame_in_t f);
      logic [31:0] gm;
      logic [31:0] gl;
      logic [31:0] gr;
      frame_out_t  e;
      gm = gain_of(master_vol);
      gl = (master_mute || left_mute) ? '0 : gain_of(left_vol);
      gr = (master_mute || right_mute) ? '0 : gain_of(right_vol);
      e.left_out  = SampleW'(apply_gain(apply_gain(longint'($signed(f.left_in)), gl), gm));
      e.right_out = SampleW'(apply_gain(apply_gain(longint'($signed(f.right_in)), gr), gm));
      scaled_q.push_back(e);
    endfunction

    function void check_frame(frame_out_t r);
      frame_out_t e;
      if (scaled_q.size() == 0) begin
        if (mismatches < ReportMax)
          $display("ERROR: unexpected result beat L=%h R=%h", r.left_out, r.right_out);
        mismatches++;
        return;
      end
      e = scaled_q.pop_front();
      if (r.left_out !== e.left_out || r.right_out !== e.right_out) begin
        if (mismatches < ReportMax)
          $display("ERROR: result mismatch exp L=%h R=%h got L=%h R=%h",
                   e.left_out, e.right_out, r.left_out, r.right_out);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             start   = 1'b0;
  logic             busy;
  frame_in_t        frame_i = '0;
  logic             done_o;
  frame_out_t       result_o;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  gain_scoreboard sb;
  int unsigned    cycles = 0;

  stereo_db_volume_mute_gain DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .frame_i  (frame_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_frame(frame_i);
    if (rst_ni && done_o) sb.check_frame(result_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return MinSample;
      1: return MaxSample;
      2: return '0;
      3: return '1;
      4: return SampleW'($urandom_range(0, 511)) - SampleW'(256);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [VolW-1:0] rand_volume();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return VolFloor;
      2: return VolW'(0 - int'($urandom_range(0, 24576)));
      3: return VolW'($urandom());
      4: return VolMaxPos;
      5: return VolMaxNeg;
      default: return VolW'(0 - int'($urandom_range(0, 1024)));
    endcase
  endfunction

  task automatic send_frame(input logic [SampleW-1:0] l, input logic [SampleW-1:0] r);
    start   <= 1'b1;
    frame_i <= '{left_in: l, right_in: r};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic sender_gap(input int unsigned pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(addr, data);
  endtask

  task automatic write_volumes(input logic [VolW-1:0] m, input logic [VolW-1:0] l,
                               input logic [VolW-1:0] r);
    write_reg(AdrMasterVol, {16'($urandom()), m});
    write_reg(AdrLeftVol, {16'($urandom()), l});
    write_reg(AdrRightVol, {16'($urandom()), r});
  endtask

  task automatic write_mutes(input logic m, input logic l, input logic r);
    write_reg(AdrMasterMute, {31'($urandom()), m});
    write_reg(AdrLeftMute, {31'($urandom()), l});
    write_reg(AdrRightMute, {31'($urandom()), r});
  endtask

  task automatic random_settings();
    drain_results();
    write_volumes(rand_volume(), rand_volume(), rand_volume());
    write_mutes($urandom_range(0, 9) == 0, $urandom_range(0, 4) == 0,
                $urandom_range(0, 4) == 0);
    if ($urandom_range(0, 2) == 0) write_reg(AdrSpareLo, $urandom());
    if ($urandom_range(0, 2) == 0) write_reg(AdrSpareHi, $urandom());
  endtask

  initial begin
    int unsigned idle_pct [3];
    idle_pct = '{29, 76, 0};
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unity gain at reset
    send_frame(MinSample, MaxSample);
    send_frame(MaxSample, MinSample);
    send_frame('0, '1);
    send_frame(32'd1, 32'h5555_aaaa);
    send_frame(32'haaaa_5555, 32'hffff_fffe);

    // floor of the table, no truncation, one step down
    drain_results();
    write_volumes(VolFloor, 16'hff01, 16'hfeff);
    write_mutes(1'b0, 1'b0, 1'b0);
    send_frame(MaxSample, MinSample);
    send_frame(MinSample, MaxSample);

    // saturation at both ends of the index
    drain_results();
    write_volumes(VolMaxPos, VolMaxNeg, 16'hff00);
    send_frame(MinSample, MaxSample);
    send_frame(32'h1234_5678, 32'hedcb_a988);
    drain_results();
    write_volumes('0, VolMaxPos, VolMaxNeg);
    send_frame(MaxSample, MinSample);

    // each mute alone
    drain_results();
    write_mutes(1'b1, 1'b0, 1'b0);
    send_frame(MaxSample, MinSample);
    send_frame(MinSample, 32'h0bad_f00d);
    drain_results();
    write_mutes(1'b0, 1'b1, 1'b0);
    send_frame(MaxSample, MinSample);
    send_frame(MinSample, MaxSample);
    drain_results();
    write_mutes(1'b0, 1'b0, 1'b1);
    send_frame(MaxSample, MinSample);
    send_frame(MinSample, MaxSample);

    // writes past the last register leave settings alone
    drain_results();
    write_mutes(1'b0, 1'b0, 1'b0);
    write_reg(AdrSpareLo, '1);
    write_reg(AdrSpareHi, '1);
    send_frame(MaxSample, MinSample);
    send_frame(32'h4000_0001, 32'hc000_0001);

    for (int mode = 0; mode < 3; mode++) begin
      for (int blk = 0; blk < 6; blk++) begin
        random_settings();
        for (int k = 0; k < 100; k++) begin
          send_frame(rand_sample(), rand_sample());
          if (k == 50) drain_results();
          else sender_gap(idle_pct[mode]);
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[stereo_db_volume_mute_gain.f]
hw/rtl/sdvmg_pkg.sv
hw/rtl/stereo_db_volume_mute_gain.sv
verif/stereo_db_volume_mute_gain_tb.sv
